// ----- hw/rtl/lpd_pkg.sv -----
// Shared types and constants for the lidar packet deframer.
package lpd_pkg;

    localparam int BYTE_W   = 8;
    localparam int DIST_W   = 16;
    localparam int TS_W     = 32;
    localparam int POS_W    = 4;
    localparam int CFG_IDX_W = 2;

    // Byte positions inside a ten-byte packet
    localparam logic [POS_W-1:0] POS_HUNT      = 4'd0;
    localparam logic [POS_W-1:0] POS_DIST_LAST = 4'd2;
    localparam logic [POS_W-1:0] POS_TS_LAST   = 4'd6;
    localparam logic [POS_W-1:0] POS_DATA_LAST = 4'd7;
    localparam logic [POS_W-1:0] POS_CHECKSUM  = 4'd8;
    localparam logic [POS_W-1:0] POS_FOOTER    = 4'd9;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOOTER = 2'd1;

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hAA;
    localparam logic [BYTE_W-1:0] FOOTER_RESET = 8'h55;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } byte_xfer_t;

    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] distance;
        logic [TS_W-1:0]   timestamp;
    } result_t;

endpackage

// ----- hw/rtl/lpd_cfg_regs.sv -----
// Header and footer configuration registers.
module lpd_cfg_regs
    import lpd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [BYTE_W-1:0]    wr_data,
    output logic [BYTE_W-1:0]    header_value,
    output logic [BYTE_W-1:0]    footer_value
);

    logic [BYTE_W-1:0] header_reg;
    logic [BYTE_W-1:0] footer_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= HEADER_RESET;
            footer_reg <= FOOTER_RESET;
        end
        else if (wr_en)
        begin
            // Drop writes to indexes beyond the register list
            unique case (wr_index)
                CFG_HEADER: header_reg <= wr_data;
                CFG_FOOTER: footer_reg <= wr_data;
                default:    ;
            endcase
        end
    end

    assign header_value = header_reg;
    assign footer_value = footer_reg;

endmodule

// ----- hw/rtl/lpd_input_stage.sv -----
// Input register for received bytes.
module lpd_input_stage
    import lpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [BYTE_W-1:0] in_data,
    output logic              in_stall,
    input  logic              consume,
    output byte_xfer_t        held
);

    logic              valid_reg;
    logic [BYTE_W-1:0] data_reg;
    logic              advance;

    // Refill whenever the slot is empty or its byte is taken this cycle
    assign advance  = !valid_reg || consume;
    assign in_stall = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            data_reg <= in_data;
        end
    end

    assign held.valid = valid_reg;
    assign held.data  = data_reg;

endmodule

// ----- hw/rtl/lpd_framer.sv -----
// Packet position tracking, field assembly and checksum/footer check.
module lpd_framer
    import lpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [BYTE_W-1:0] rx,
    input  logic [BYTE_W-1:0] header_value,
    input  logic [BYTE_W-1:0] footer_value,
    output result_t           res
);

    logic [POS_W-1:0]  pos_reg,  pos_next;
    logic [BYTE_W-1:0] xor_reg,  xor_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic [TS_W-1:0]   ts_reg,   ts_next;
    logic              chk_reg,  chk_next;
    logic              hunting;

    assign hunting = (pos_reg == POS_HUNT) || (pos_reg > POS_FOOTER);

    always_comb
    begin
        pos_next  = pos_reg;
        xor_next  = xor_reg;
        dist_next = dist_reg;
        ts_next   = ts_reg;
        chk_next  = chk_reg;
        res.valid     = 1'b0;
        res.distance  = dist_reg;
        res.timestamp = ts_reg;
        if (fire)
        begin
            priority if (hunting)
            begin
                if (rx == header_value)
                begin
                    pos_next = POS_HUNT + 4'd1;
                    xor_next = '0;
                    chk_next = 1'b0;
                end
                else
                begin
                    pos_next = POS_HUNT;
                end
            end
            else if (pos_reg <= POS_DATA_LAST)
            begin
                xor_next = xor_reg ^ rx;
                if (pos_reg <= POS_DIST_LAST)
                begin
                    dist_next = {rx, dist_reg[DIST_W-1:BYTE_W]};
                end
                else if (pos_reg <= POS_TS_LAST)
                begin
                    ts_next = {rx, ts_reg[TS_W-1:BYTE_W]};
                end
                pos_next = pos_reg + 4'd1;
            end
            else if (pos_reg == POS_CHECKSUM)
            begin
                chk_next = (rx == xor_reg);
                pos_next = POS_FOOTER;
            end
            else
            begin
                pos_next  = POS_HUNT;
                res.valid = chk_reg && (rx == footer_value);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_HUNT;
            chk_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            chk_reg <= chk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xor_reg  <= xor_next;
        dist_reg <= dist_next;
        ts_reg   <= ts_next;
    end

endmodule

// ----- hw/rtl/lpd_output_stage.sv -----
// Result register toward the consumer.
module lpd_output_stage
    import lpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  result_t           res,
    input  logic              out_stall,
    output logic              out_valid,
    output logic              can_load,
    output logic [DIST_W-1:0] distance,
    output logic [TS_W-1:0]   timestamp
);

    logic              valid_reg;
    logic [DIST_W-1:0] dist_reg;
    logic [TS_W-1:0]   ts_reg;

    // A new result may land when the register is empty or draining now
    assign can_load = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res.valid)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            dist_reg <= res.distance;
            ts_reg   <= res.timestamp;
        end
    end

    assign out_valid = valid_reg;
    assign distance  = dist_reg;
    assign timestamp = ts_reg;

endmodule

// ----- hw/rtl/lidar_packet_deframer_unit.sv -----
// Top level of the lidar packet deframer.
//
//  Channel  | Direction | Handshake           | Payload
//  ---------+-----------+---------------------+----------------------------------
//  in       | input     | in_valid / in_stall | rx_byte[7:0]
//  out      | output    | out_valid/out_stall | distance_mm[15:0], timestamp_ms[31:0]
//  cfg      | input     | cfg_valid/cfg_ready | cfg_index[1:0], cfg_data[7:0]
//
//  One byte per cycle sustained unless the result register holds a stalled result. A byte
//  is held in the input register, then updates the packet state while a footer byte that
//  passes both checks loads the result register.
//  rst_n asynchronously clears positions and valids; header/footer return to 0xAA/0x55.
//  in_stall rises only while a byte waits and the result register holds a stalled
//  transaction; cfg_ready is always high.
module lidar_packet_deframer_unit
    import lpd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [BYTE_W-1:0]    rx_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [DIST_W-1:0]    distance_mm,
    output logic [TS_W-1:0]      timestamp_ms,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data
);

    logic [BYTE_W-1:0] header_value;
    logic [BYTE_W-1:0] footer_value;
    byte_xfer_t        held;
    result_t           res;
    logic              can_load;
    logic              fire;

    // Register writes are taken in any cycle
    assign cfg_ready = 1'b1;

    lpd_cfg_regs u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (cfg_valid && cfg_ready),
        .wr_index     (cfg_index),
        .wr_data      (cfg_data),
        .header_value (header_value),
        .footer_value (footer_value)
    );

    // Process the held byte only when a possible result has somewhere to go
    assign fire = held.valid && can_load;

    lpd_input_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_data  (rx_byte),
        .in_stall (in_stall),
        .consume  (fire),
        .held     (held)
    );

    lpd_framer u_framer (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .rx           (held.data),
        .header_value (header_value),
        .footer_value (footer_value),
        .res          (res)
    );

    lpd_output_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .can_load  (can_load),
        .distance  (distance_mm),
        .timestamp (timestamp_ms)
    );

endmodule
